### rtl/hfv_pkg.sv
package hfv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned OFF_W   = 9;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_DIGITS     = 3'd4;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0]  START_CODE_RST     = 8'h01;
    localparam logic [BYTE_W-1:0]  END_CODE_RST       = 8'h0a;
    localparam logic [BYTE_W-1:0]  BROADCAST_CODE_RST = 8'h0f;
    localparam logic [OFF_W-1:0]   LEN_OFFSET_RST     = 9'd3;
    localparam logic [DIGIT_W-1:0] LEN_DIGITS_RST     = 4'd3;

    // frame layout constants
    localparam logic [COUNT_W-1:0] TAIL_DEPTH  = 10'd3;
    localparam logic [COUNT_W:0]   MIN_LEN     = 11'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1023;
    localparam logic [COUNT_W-1:0] POS_START   = 10'd0;
    localparam logic [COUNT_W-1:0] POS_BCAST   = 10'd1;

    typedef struct packed {
        logic [BYTE_W-1:0]  start_code;
        logic [BYTE_W-1:0]  end_code;
        logic [BYTE_W-1:0]  broadcast_code;
        logic [OFF_W-1:0]   len_field_offset;
        logic [DIGIT_W-1:0] len_field_digits;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_item_t;

    // lowercase hex digit decode, anything else reads as zero
    function automatic logic [DIGIT_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
            end
            return d[DIGIT_W-1:0];
        end
    endfunction

endpackage

### rtl/hfv_in_stage.sv
module hfv_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hfv_pkg::byte_item_t in_item,
    input  logic               advance,
    output logic               item_valid,
    output hfv_pkg::byte_item_t item
);
    import hfv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    // slot frees when empty or when the held byte moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/hfv_checker.sv
module hfv_checker #(
    parameter int unsigned MAX_FRAME_BYTES = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hfv_pkg::cfg_t       cfg,
    input  logic                fire,
    input  hfv_pkg::byte_item_t item,
    output logic                res_valid,
    output logic                res_bad
);
    import hfv_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(MAX_FRAME_BYTES);

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [BYTE_W-1:0]  xor_reg,     xor_next;
    logic [BYTE_W-1:0]  tail_reg [3];
    logic [BYTE_W-1:0]  tail_next [3];
    logic               start_ok_reg, start_ok_next;
    logic               bcast_reg,    bcast_next;
    logic [LEN_W-1:0]   len_val_reg,  len_val_next;
    logic               ovf_reg,      ovf_next;

    logic [COUNT_W-1:0] field_end;
    logic               in_field;
    logic [COUNT_W:0]   frame_len;
    logic [COUNT_W:0]   body_len;
    logic [BYTE_W-1:0]  recv_sum;
    logic               bad;

    always_comb
    begin
        field_end = {1'b0, cfg.len_field_offset}
                  + {{(COUNT_W-DIGIT_W){1'b0}}, cfg.len_field_digits};
        in_field  = (count_reg >= {1'b0, cfg.len_field_offset}) && (count_reg < field_end);

        ovf_next      = ovf_reg || (count_reg >= MAX_BYTES);
        start_ok_next = (count_reg == POS_START) ? (item.data == cfg.start_code)
                                                 : start_ok_reg;
        bcast_next    = (count_reg == POS_BCAST) ? (item.data == cfg.broadcast_code)
                                                 : bcast_reg;
        len_val_next  = in_field ? {len_val_reg[LEN_W-DIGIT_W-1:0], hex_val(item.data)}
                                 : len_val_reg;
        // oldest window byte joins the checksum
        xor_next      = (count_reg >= TAIL_DEPTH) ? (xor_reg ^ tail_reg[0]) : xor_reg;

        frame_len = {1'b0, count_reg} + 11'd1;
        body_len  = frame_len - {1'b0, TAIL_DEPTH};
        recv_sum  = {hex_val(tail_reg[1]), hex_val(tail_reg[2])};

        bad = ovf_next || !start_ok_next || (item.data != cfg.end_code)
           || (frame_len < MIN_LEN) || (xor_next != recv_sum)
           || (bcast_next && ((frame_len < {1'b0, field_end})
                              || (len_val_next != {{(LEN_W-COUNT_W-1){1'b0}}, body_len})));

        tail_next[0] = tail_reg[1];
        tail_next[1] = tail_reg[2];
        tail_next[2] = item.data;
        count_next   = (count_reg < COUNT_MAX) ? (count_reg + 10'd1) : count_reg;
    end

    assign res_valid = fire && item.last;
    assign res_bad   = bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            xor_reg      <= '0;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
            tail_reg[2]  <= '0;
            start_ok_reg <= 1'b0;
            bcast_reg    <= 1'b0;
            len_val_reg  <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                count_reg    <= '0;
                xor_reg      <= '0;
                tail_reg[0]  <= '0;
                tail_reg[1]  <= '0;
                tail_reg[2]  <= '0;
                start_ok_reg <= 1'b0;
                bcast_reg    <= 1'b0;
                len_val_reg  <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                xor_reg      <= xor_next;
                tail_reg[0]  <= tail_next[0];
                tail_reg[1]  <= tail_next[1];
                tail_reg[2]  <= tail_next[2];
                start_ok_reg <= start_ok_next;
                bcast_reg    <= bcast_next;
                len_val_reg  <= len_val_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule

### rtl/hfv_out_stage.sv
module hfv_out_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  logic res_bad,
    output logic can_take,
    output logic out_valid,
    input  logic out_ready,
    output logic frame_bad
);
    import hfv_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic bad_reg;

    assign can_take   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            bad_reg <= res_bad;
        end
    end

    assign out_valid = valid_reg;
    assign frame_bad = bad_reg;

endmodule

### rtl/hex_frame_verifier.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | data_byte[7:0], last_byte
// out      | out_valid / out_ready| frame_bad (one item per frame, at last byte)
// cfg      | cfg_wr_en            | cfg_wr_index[2:0], cfg_wr_data[8:0]
//
// one byte accepted per cycle unless stalled; the verdict is registered
// the frame state lives in the checker and updates from the input register;
// the verdict lands in a result register that decouples the outputs
// reset clears all control state and restores the register reset values
// only a last byte can wait: it stalls while the result register holds an
// untaken verdict, and in_ready drops only then
module hex_frame_verifier #(
    parameter int unsigned MAX_FRAME_BYTES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hfv_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          frame_bad,
    input  logic                          cfg_wr_en,
    input  logic [hfv_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [hfv_pkg::CFG_W-1:0]     cfg_wr_data
);
    import hfv_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    // input register to checker
    byte_item_t in_item;
    byte_item_t s1_item;
    logic       s1_valid;
    logic       s1_advance;
    logic       chk_fire;

    // checker to result register
    logic       res_valid;
    logic       res_bad;
    logic       can_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                CFG_START_CODE:     cfg_next.start_code       = cfg_wr_data[BYTE_W-1:0];
                CFG_END_CODE:       cfg_next.end_code         = cfg_wr_data[BYTE_W-1:0];
                CFG_BROADCAST_CODE: cfg_next.broadcast_code   = cfg_wr_data[BYTE_W-1:0];
                CFG_LEN_OFFSET:     cfg_next.len_field_offset = cfg_wr_data[OFF_W-1:0];
                CFG_LEN_DIGITS:     cfg_next.len_field_digits = cfg_wr_data[DIGIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code       <= START_CODE_RST;
            cfg_reg.end_code         <= END_CODE_RST;
            cfg_reg.broadcast_code   <= BROADCAST_CODE_RST;
            cfg_reg.len_field_offset <= LEN_OFFSET_RST;
            cfg_reg.len_field_digits <= LEN_DIGITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.data = data_byte;
    assign in_item.last = last_byte;

    // a non-final byte never produces a verdict, so it always moves on
    assign s1_advance = !s1_item.last || can_take;
    assign chk_fire   = s1_valid && s1_advance;

    hfv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (s1_advance),
        .item_valid (s1_valid),
        .item       (s1_item)
    );

    hfv_checker #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (chk_fire),
        .item      (s1_item),
        .res_valid (res_valid),
        .res_bad   (res_bad)
    );

    hfv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_bad   (res_bad),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_bad (frame_bad)
    );

    // a verdict is only produced when the result register can hold it
    a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid || out_ready))
        else $error("verdict produced while result register is full");

    // a non-final byte leaves the output occupancy to the consumer alone
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_fire && !s1_item.last) |=> (out_valid == $past(out_valid && !out_ready)))
        else $error("result appeared without a final byte");

    // input stalls only behind an untaken verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && s1_valid && s1_item.last))
        else $error("input stalled without a blocked final byte");

endmodule
